[rtl/line_rasterizer_core_defines.svh]
// Assertion macros for the line rasteriser core.
// Depends on nothing; files that use the macros must have i_clk and i_rst_n in scope.
`ifndef LINE_RASTERIZER_CORE_DEFINES_SVH
`define LINE_RASTERIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LRC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LRC_ASSERT(lbl, prop, msg)
`define LRC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/lr_pkg.sv]
// Package for the line rasteriser: coordinate widths, word types and sequencer states.
// Depends on nothing.
`default_nettype none
package lr_pkg;

    localparam int COORD_BITS = 6;
    localparam int COLOR_BITS = 24;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [COLOR_BITS-1:0] line_color;
    } t_line_cmd;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } t_pixel;

    typedef struct packed {
        logic signed [ERR_BITS-1:0] err;
        logic                       step;
    } t_step_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } t_state;

endpackage
`default_nettype wire

[rtl/lr_step_unit.sv]
// Error-term unit: adds twice the minor extent, tests against the major extent
// and folds the error back when the minor axis steps. Depends on lr_pkg.
`default_nettype none
module lr_step_unit (
    input  wire logic signed [lr_pkg::ERR_BITS-1:0]   i_err,
    input  wire logic        [lr_pkg::COORD_BITS-1:0] i_minor,
    input  wire logic        [lr_pkg::COORD_BITS-1:0] i_major,
    input  wire logic                                 i_xmaj,
    output lr_pkg::t_step_res                         o_res
);
    import lr_pkg::*;

    logic signed [ERR_BITS-1:0] minor2;
    logic signed [ERR_BITS-1:0] major1;
    logic signed [ERR_BITS-1:0] major2;
    logic signed [ERR_BITS-1:0] sum;
    logic                       step;

    assign minor2 = $signed({2'b00, i_minor, 1'b0});
    assign major1 = $signed({3'b000, i_major});
    assign major2 = $signed({2'b00, i_major, 1'b0});
    assign sum    = i_err + minor2;
    assign step   = i_xmaj ? (sum > major1) : (sum >= major1);

    always_comb begin
        o_res.step = step;
        o_res.err  = step ? (sum - major2) : sum;
    end

endmodule
`default_nettype wire

[rtl/line_rasterizer_core.sv]
// Line rasteriser core: a Bresenham sequencer around one shared error-term unit.
// Depends on lr_pkg, lr_step_unit and line_rasterizer_core_defines.svh.
//
// A command word is taken when start is high and busy is low. A line of n pixels
// (n = max(|dx|,|dy|) + 1, at most 64) keeps busy high after the accepting edge
// while the block first sorts the endpoints, then gives one pixel per cycle, set by the
// single error-term unit that advances the walk once a cycle. Each pixel word appears
// for one cycle with o_pixel_strobe high, in the cycle after it is produced; the last
// carries last_pixel. The receiver cannot stall the block, so it must take every
// pixel word in the cycle it is shown. A new command may be issued in the cycle that
// shows the last pixel.
`default_nettype none
`include "line_rasterizer_core_defines.svh"
module line_rasterizer_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire lr_pkg::t_line_cmd i_cmd,
    output logic               busy,
    output lr_pkg::t_pixel     o_pixel,
    output logic               o_pixel_strobe
);
    import lr_pkg::*;

    t_state                      r_state, n_state;
    t_line_cmd                   r_cmd, n_cmd;
    logic [COORD_BITS-1:0]       r_p, n_p;
    logic [COORD_BITS-1:0]       r_q, n_q;
    logic [COORD_BITS-1:0]       r_len, n_len;
    logic [COORD_BITS-1:0]       r_min, n_min;
    logic [COORD_BITS-1:0]       r_cnt, n_cnt;
    logic signed [ERR_BITS-1:0]  r_err, n_err;
    logic                        r_xmaj, n_xmaj;
    logic                        r_maj_up, n_maj_up;
    logic                        r_min_up, n_min_up;
    t_pixel                      r_out, n_out;
    logic                        r_strobe, n_strobe;

    logic [COORD_BITS-1:0] s_adx, s_ady, s_p, s_q, s_len, s_min;
    logic                  s_xmaj, s_maj_up, s_min_up;
    t_step_res             step_res;

    always_comb begin
        logic [COORD_BITS-1:0] x0, y0, x1, y1, qf;
        x0 = r_cmd.x_start;
        y0 = r_cmd.y_start;
        x1 = r_cmd.x_end;
        y1 = r_cmd.y_end;
        s_adx = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
        s_ady = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
        s_xmaj = (s_adx != '0) && (s_ady <= s_adx);
        if (s_adx == '0) begin
            s_p      = y0;
            s_q      = x0;
            qf       = x0;
            s_maj_up = (y1 >= y0);
            s_len    = s_ady;
            s_min    = '0;
        end else if (s_xmaj) begin
            s_p      = (x0 < x1) ? x0 : x1;
            s_q      = (x0 < x1) ? y0 : y1;
            qf       = (x0 < x1) ? y1 : y0;
            s_maj_up = 1'b1;
            s_len    = s_adx;
            s_min    = s_ady;
        end else begin
            s_p      = (y0 < y1) ? y0 : y1;
            s_q      = (y0 < y1) ? x0 : x1;
            qf       = (y0 < y1) ? x1 : x0;
            s_maj_up = 1'b1;
            s_len    = s_ady;
            s_min    = s_adx;
        end
        s_min_up = (qf >= s_q);
    end

    lr_step_unit u_step (
        .i_err   (r_err),
        .i_minor (r_min),
        .i_major (r_len),
        .i_xmaj  (r_xmaj),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_p      <= n_p;
        r_q      <= n_q;
        r_len    <= n_len;
        r_min    <= n_min;
        r_cnt    <= n_cnt;
        r_err    <= n_err;
        r_xmaj   <= n_xmaj;
        r_maj_up <= n_maj_up;
        r_min_up <= n_min_up;
        r_out    <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_p      = r_p;
        n_q      = r_q;
        n_len    = r_len;
        n_min    = r_min;
        n_cnt    = r_cnt;
        n_err    = r_err;
        n_xmaj   = r_xmaj;
        n_maj_up = r_maj_up;
        n_min_up = r_min_up;
        n_out    = r_out;
        n_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_p      = s_p;
                n_q      = s_q;
                n_len    = s_len;
                n_min    = s_min;
                n_cnt    = s_len;
                n_err    = '0;
                n_xmaj   = s_xmaj;
                n_maj_up = s_maj_up;
                n_min_up = s_min_up;
                n_state  = S_RUN;
            end
            S_RUN: begin
                n_strobe          = 1'b1;
                n_out.pixel_x     = r_xmaj ? r_p : r_q;
                n_out.pixel_y     = r_xmaj ? r_q : r_p;
                n_out.pixel_color = r_cmd.line_color;
                n_out.last_pixel  = (r_cnt == '0);
                n_p   = r_maj_up ? (r_p + 1'b1) : (r_p - 1'b1);
                if (step_res.step) begin
                    n_q = r_min_up ? (r_q + 1'b1) : (r_q - 1'b1);
                end
                n_err = step_res.err;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_pixel        = r_out;
    assign o_pixel_strobe = r_strobe;

    `LRC_ASSERT(a_accept_busy, start && !busy |=> busy, "Accepted command did not raise busy.")
    `LRC_ASSERT(a_mid_line_busy, o_pixel_strobe && !o_pixel.last_pixel |-> busy,
                "Pixel before the last shown while idle.")
    `LRC_ASSERT(a_last_gap, o_pixel_strobe && o_pixel.last_pixel |=> !o_pixel_strobe,
                "Pixel word followed the last pixel of a line.")
    `LRC_ASSERT(a_err_bound,
                r_state == S_RUN |-> r_err <= $signed({{(ERR_BITS-COORD_BITS){1'b0}}, r_len}),
                "Error term exceeded the major extent.")
    `LRC_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_pixel_strobe && !busy,
                    "Block active after reset.")

endmodule
`default_nettype wire

[tb/sv/tb_line_rasterizer_core.sv]
// Testbench for line_rasterizer_core: line command words go in random bursts, and every pixel
// word that comes back is checked against a Bresenham walk kept in the testbench or a typed word.
// Depends on lr_pkg and line_rasterizer_core.
module tb_line_rasterizer_core;
    import lr_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RANDOM_LINES = 410;
    localparam int IDLE_LIMIT   = 2000;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

    typedef enum bit {ROW_PREDICTED, ROW_TYPED} t_row_kind;

    typedef struct {
        t_line_cmd cmd;
        t_row_kind kind;
        t_pixel    pixel;
    } t_dir_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_line_cmd i_cmd   = '0;
    logic      busy;
    t_pixel    o_pixel;
    logic      o_pixel_strobe;

    t_pixel    expected_pixels[$];
    t_dir_row  dir_rows[$];
    int        errors      = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;

    always #CLK_HALF i_clk = ~i_clk;

    line_rasterizer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .busy           (busy),
        .o_pixel        (o_pixel),
        .o_pixel_strobe (o_pixel_strobe)
    );

    function automatic t_line_cmd mk_line(int x0, int y0, int x1, int y1,
                                          logic [COLOR_BITS-1:0] color);
        t_line_cmd c;
        c.x_start    = x0[COORD_BITS-1:0];
        c.y_start    = y0[COORD_BITS-1:0];
        c.x_end      = x1[COORD_BITS-1:0];
        c.y_end      = y1[COORD_BITS-1:0];
        c.line_color = color;
        return c;
    endfunction

    function automatic t_pixel mk_pixel(int x, int y, logic [COLOR_BITS-1:0] color, bit last);
        t_pixel p;
        p.pixel_x     = x[COORD_BITS-1:0];
        p.pixel_y     = y[COORD_BITS-1:0];
        p.pixel_color = color;
        p.last_pixel  = last;
        return p;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Walks the line along its major axis and queues the pixel words it should produce.
    function automatic void trace_line(t_line_cmd c);
        int x0  = int'(c.x_start);
        int y0  = int'(c.y_start);
        int x1  = int'(c.x_end);
        int y1  = int'(c.y_end);
        int adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
        int ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
        int x;
        int y;
        int step;
        int err;
        err = 0;
        if (adx == 0) begin
            step = (y1 >= y0) ? 1 : -1;
            for (int i = 0; i <= ady; i++)
                expected_pixels.push_back(mk_pixel(x0, y0 + i * step, c.line_color, i == ady));
        end else if (ady <= adx) begin
            x    = (x0 < x1) ? x0 : x1;
            y    = (x0 < x1) ? y0 : y1;
            step = (((x0 < x1) ? y1 : y0) >= y) ? 1 : -1;
            for (int i = 0; i <= adx; i++) begin
                if (i > 0) begin
                    err += 2 * ady;
                    if (err > adx) begin
                        err -= 2 * adx;
                        y   += step;
                    end
                end
                expected_pixels.push_back(mk_pixel(x + i, y, c.line_color, i == adx));
            end
        end else begin
            y    = (y0 < y1) ? y0 : y1;
            x    = (y0 < y1) ? x0 : x1;
            step = (((y0 < y1) ? x1 : x0) >= x) ? 1 : -1;
            for (int i = 0; i <= ady; i++) begin
                if (i > 0) begin
                    err += 2 * adx;
                    if (err >= ady) begin
                        err -= 2 * ady;
                        x   += step;
                    end
                end
                expected_pixels.push_back(mk_pixel(x, y + i, c.line_color, i == ady));
            end
        end
    endfunction

    // Commands go out in bursts; between bursts the start line may drop for a while.
    task automatic issue_line(input t_line_cmd cmd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 6);
                default: gap = $urandom_range(7, 70);
            endcase
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_lines();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_pixel_strobe) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel word with none expected: x=%0d y=%0d colour=%06h last=%0b",
                         $time, o_pixel.pixel_x, o_pixel.pixel_y, o_pixel.pixel_color,
                         o_pixel.last_pixel);
            end else begin
                want = expected_pixels[0];
                expected_pixels.delete(0);
                if (o_pixel !== want) begin
                    errors++;
                    $display("%0t: pixel mismatch: expected x=%0d y=%0d colour=%06h last=%0b",
                             $time, want.pixel_x, want.pixel_y, want.pixel_color,
                             want.last_pixel);
                    $display("%0t:                 actual   x=%0d y=%0d colour=%06h last=%0b",
                             $time, o_pixel.pixel_x, o_pixel.pixel_y, o_pixel.pixel_color,
                             o_pixel.last_pixel);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_pixel_strobe)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_line_cmd cmd;
        int        pick;
        int        x0;
        int        y0;
        int        x1;
        int        y1;
        int        len;

        // A degenerate line gives one pixel word at the endpoint, flagged as the last.
        dir_rows.push_back('{mk_line(0, 0, 0, 0, 24'h000000), ROW_TYPED,
                             mk_pixel(0, 0, 24'h000000, 1'b1)});
        dir_rows.push_back('{mk_line(63, 63, 63, 63, 24'hFFFFFF), ROW_TYPED,
                             mk_pixel(63, 63, 24'hFFFFFF, 1'b1)});
        dir_rows.push_back('{mk_line(17, 42, 17, 42, 24'hA5C3F0), ROW_TYPED,
                             mk_pixel(17, 42, 24'hA5C3F0, 1'b1)});
        dir_rows.push_back('{mk_line(0, 5, 63, 5, 24'hFF0000), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(63, 60, 0, 60, 24'h00FF00), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(3, 0, 3, 63, 24'h0000FF), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(60, 63, 60, 0, 24'h800001), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(10, 20, 10, 21, 24'h7FFFFE), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(0, 0, 63, 63, 24'h123456), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(63, 0, 0, 63, 24'h654321), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(63, 63, 0, 0, 24'hAAAAAA), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(2, 3, 50, 20, 24'h555555), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(50, 20, 2, 3, 24'h0F0F0F), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(5, 40, 60, 30, 24'hF0F0F0), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(60, 30, 5, 40, 24'h00FFFF), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(3, 2, 20, 50, 24'hFF00FF), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(20, 50, 3, 2, 24'hFFFF00), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(40, 5, 30, 60, 24'h010203), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(30, 60, 40, 5, 24'hFEDCBA), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(10, 0, 11, 63, 24'h3C3C3C), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(0, 10, 63, 11, 24'hC3C3C3), ROW_PREDICTED, '0});
        dir_rows.push_back('{mk_line(7, 7, 8, 7, 24'h9ABCDE), ROW_PREDICTED, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            issue_line(dir_rows[r].cmd);
            if (dir_rows[r].kind == ROW_TYPED)
                expected_pixels.push_back(dir_rows[r].pixel);
            else
                trace_line(dir_rows[r].cmd);
        end
        drain_lines();

        for (int n = 0; n < RANDOM_LINES; n++) begin
            pick = $urandom_range(0, 99);
            x0   = $urandom_range(0, COORD_MAX);
            y0   = $urandom_range(0, COORD_MAX);
            x1   = $urandom_range(0, COORD_MAX);
            y1   = $urandom_range(0, COORD_MAX);
            if (pick < 45) begin
                // Endpoints anywhere in the tile.
            end else if (pick < 65) begin
                x1 = clamp_coord(x0 + $urandom_range(0, 8) - 4);
                y1 = clamp_coord(y0 + $urandom_range(0, 8) - 4);
            end else if (pick < 75) begin
                y1 = y0;
            end else if (pick < 85) begin
                x1 = x0;
            end else if (pick < 93) begin
                len = (x1 >= x0) ? x1 - x0 : x0 - x1;
                if ($urandom_range(0, 1) == 1) begin
                    y0 = $urandom_range(0, COORD_MAX - len);
                    y1 = y0 + len;
                end else begin
                    y0 = $urandom_range(len, COORD_MAX);
                    y1 = y0 - len;
                end
            end else begin
                x1 = x0;
                y1 = y0;
            end
            cmd = mk_line(x0, y0, x1, y1, COLOR_BITS'($urandom_range(0, 24'hFFFFFF)));
            issue_line(cmd);
            trace_line(cmd);
            if (n % 100 == 99)
                drain_lines();
        end

        start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
